FILE: sv/rle_dc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_dc_pkg
// shared types and constants of the digit-count run-length encoder
// ----------------------------------------------------------------------------
package rle_dc_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 4;
    localparam int MAX_CODES = 4;
    localparam int NCODE_W   = 3;   // holds 0..MAX_CODES

    localparam logic [COUNT_W-1:0] RUN_MAX    = 4'd9;
    localparam logic [BYTE_W-1:0]  DIGIT_ZERO = 8'h30;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } code_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  run_val;
        logic [COUNT_W-1:0] run_count;
        logic               run_open;
    } run_state_t;

endpackage

FILE: sv/rle_digit_count_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_digit_count_encoder_core
// run-length encoder with single-digit counts on byte streams
// ----------------------------------------------------------------------------
// offer: the first code byte of an input transfer is offered in the cycle after it
// throughput: one input transfer per cycle while it causes no code bytes; an input
//   causing code bytes (up to four) holds the input side until the last of them
//   leaves the code buffer through the byte-wide output
// reset: clears the run state (no run open) and empties the code buffer
// ----------------------------------------------------------------------------
module rle_digit_count_encoder_core (
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       in_tvalid,
    output logic       in_tready,
    input  logic [7:0] in_tdata,   // [7:0] in_byte
    input  logic       in_tlast,   // in_last
    // output stream
    output logic       out_tvalid,
    input  logic       out_tready,
    output logic [7:0] out_tdata,  // [7:0] out_byte
    output logic       out_tlast   // out_last
);
    import rle_dc_pkg::*;

    // run state carried between input transfers
    run_state_t run_reg;
    run_state_t run_next;

    // code buffer: entry 0 is the byte on offer, shifts down on each output transfer
    code_t [MAX_CODES-1:0]  codes_reg;
    code_t [MAX_CODES-1:0]  codes_new;
    logic [NCODE_W-1:0]     n_new;
    logic [NCODE_W-1:0]     rem_reg;

    logic in_xfer;
    logic out_xfer;

    // encoding of one input byte against the open run
    rle_dc_coder u_coder (
        .cur     (run_reg),
        .in_byte (in_tdata),
        .in_last (in_tlast),
        .nxt     (run_next),
        .codes   (codes_new),
        .n_codes (n_new)
    );

    assign out_tvalid = (rem_reg != '0);
    assign out_tdata  = codes_reg[0].value;
    assign out_tlast  = codes_reg[0].last;
    assign out_xfer   = out_tvalid && out_tready;

    // take the next byte once the buffer is empty or its final code leaves now
    assign in_tready  = (rem_reg == '0) || ((rem_reg == NCODE_W'(1)) && out_tready);
    assign in_xfer    = in_tvalid && in_tready;

    // control: run state and buffer fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                run_reg <= run_next;
                rem_reg <= n_new;
            end
            else if (out_xfer)
            begin
                rem_reg <= rem_reg - NCODE_W'(1);
            end
        end
    end

    // payload: code bytes, loaded on input transfer, shifted on output transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            codes_reg <= codes_new;
        end
        else if (out_xfer)
        begin
            for (int i = 0; i < MAX_CODES - 1; i++)
                codes_reg[i] <= codes_reg[i+1];
            codes_reg[MAX_CODES-1] <= '0;
        end
    end

endmodule

FILE: sv/rle_dc_coder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_dc_coder
// next run state and the code bytes caused by one input byte
// ----------------------------------------------------------------------------
module rle_dc_coder (
    input  rle_dc_pkg::run_state_t                          cur,
    input  logic [rle_dc_pkg::BYTE_W-1:0]                   in_byte,
    input  logic                                            in_last,
    output rle_dc_pkg::run_state_t                          nxt,
    output rle_dc_pkg::code_t [rle_dc_pkg::MAX_CODES-1:0]   codes,
    output logic [rle_dc_pkg::NCODE_W-1:0]                  n_codes
);
    import rle_dc_pkg::*;

    code_t      a_codes [3];
    code_t      f_codes [3];
    logic [1:0] a_n;
    logic [1:0] f_n;
    run_state_t st1;
    logic [2:0] j;
    logic [COUNT_W-1:0] dig;

    // digit byte for a run count, clamped to nine
    function automatic logic [BYTE_W-1:0] digit_of(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] cc;
        cc = (c > RUN_MAX) ? RUN_MAX : c;
        return DIGIT_ZERO + {{(BYTE_W-COUNT_W){1'b0}}, cc};
    endfunction

    always_comb
    begin
        a_codes = '{default: '0};
        f_codes = '{default: '0};
        a_n     = 2'd0;
        f_n     = 2'd0;
        st1     = cur;
        dig     = RUN_MAX;

        // continue, split or close the open run
        if (cur.run_open && in_byte == cur.run_val)
        begin
            if (cur.run_count >= RUN_MAX)
            begin
                a_codes[0] = '{value: cur.run_val, last: 1'b0};
                a_codes[1] = '{value: cur.run_val, last: 1'b0};
                a_codes[2] = '{value: digit_of(RUN_MAX), last: 1'b0};
                a_n        = 2'd3;
                st1.run_count = 4'd1;
            end
            else
            begin
                st1.run_count = cur.run_count + 4'd1;
            end
        end
        else
        begin
            if (cur.run_open)
            begin
                if (cur.run_count <= 4'd1)
                begin
                    a_codes[0] = '{value: cur.run_val, last: 1'b0};
                    a_n        = 2'd1;
                end
                else
                begin
                    a_codes[0] = '{value: cur.run_val, last: 1'b0};
                    a_codes[1] = '{value: cur.run_val, last: 1'b0};
                    a_codes[2] = '{value: digit_of(cur.run_count), last: 1'b0};
                    a_n        = 2'd3;
                end
            end
            st1.run_val   = in_byte;
            st1.run_count = 4'd1;
            st1.run_open  = 1'b1;
        end

        // end of string: flush what is open
        if (in_last)
        begin
            dig = st1.run_count;
            if (st1.run_count <= 4'd1)
            begin
                f_codes[0] = '{value: st1.run_val, last: 1'b1};
                f_n        = 2'd1;
            end
            else
            begin
                f_codes[0] = '{value: st1.run_val, last: 1'b0};
                f_codes[1] = '{value: st1.run_val, last: 1'b0};
                f_codes[2] = '{value: digit_of(dig), last: 1'b1};
                f_n        = 2'd3;
            end
        end

        nxt     = in_last ? '0 : st1;
        n_codes = {1'b0, a_n} + {1'b0, f_n};

        // concatenate the two code lists
        for (int i = 0; i < MAX_CODES; i++)
        begin
            j        = 3'(i) - {1'b0, a_n};
            codes[i] = '0;
            if (3'(i) < {1'b0, a_n})
                codes[i] = a_codes[i[1:0]];
            else if (j < {1'b0, f_n})
                codes[i] = f_codes[j[1:0]];
        end
    end

endmodule
